// ===== hw/rtl/gift128_pkg.sv =====
package gift128_pkg;

	localparam int unsigned BLK_W  = 128;
	localparam int unsigned HALF_W = 64;
	localparam int unsigned RND_W  = 6;

	localparam logic [RND_W-1:0] MAX_ROUNDS = 6'd40;
	localparam logic [RND_W-1:0] RESET_ROUNDS = 6'd40;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_LOW     = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH    = 2'd1;
	localparam logic [1:0] REG_ROUND_COUNT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic             load;      // take a new request into the state register
		logic             step;      // apply one round
		logic             out_load;  // move the finished state to the output register
		logic [RND_W-1:0] round_idx;
	} gift128_cmd_t;

	typedef struct packed {
		logic [RND_W-1:0] rounds;    // effective round count, 0..40
	} gift128_sts_t;

	localparam logic [3:0] SBOX [16] = '{
		4'd1, 4'd10, 4'd4, 4'd12, 4'd6, 4'd15, 4'd3, 4'd9,
		4'd2, 4'd13, 4'd11, 4'd7, 4'd5, 4'd0, 4'd8, 4'd14
	};

	// bit b goes to 4*(b/16) + PERM_BASE[b%16]
	localparam logic [6:0] PERM_BASE [16] = '{
		7'd0, 7'd33, 7'd66, 7'd99, 7'd96, 7'd1, 7'd34, 7'd67,
		7'd64, 7'd97, 7'd2, 7'd35, 7'd32, 7'd65, 7'd98, 7'd3
	};

	localparam logic [5:0] RC_TAB [40] = '{
		6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B, 6'h37, 6'h2F,
		6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E, 6'h1D, 6'h3A, 6'h35, 6'h2B,
		6'h16, 6'h2C, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E,
		6'h1C, 6'h38, 6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A
	};

	function automatic logic [5:0] round_const(input logic [RND_W-1:0] r);
		logic [5:0] c;
		c = 6'd0;
		if (r < MAX_ROUNDS) begin
			c = RC_TAB[r];
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/gift128_ctrl.sv =====
module gift128_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  logic                       out_stall,
	input  gift128_pkg::gift128_sts_t  sts,
	output gift128_pkg::gift128_cmd_t  cmd
);
	import gift128_pkg::*;

	ctrl_state_t      state_q, state_nxt;
	logic [RND_W-1:0] round_q;
	logic             out_valid_q;
	logic             out_free;
	logic             last_round;

	assign out_free   = !out_valid_q || !out_stall;
	assign last_round = (round_q == sts.rounds - 6'd1);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (sts.rounds == '0) ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_round) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.round_idx = round_q;
		in_stall      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				round_q <= '0;
			end else if (cmd.step) begin
				round_q <= round_q + 6'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/gift128_dp.sv =====
module gift128_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [63:0]                cfg_data,
	input  logic [63:0]                data_low,
	input  logic [63:0]                data_high,
	output logic [63:0]                cipher_low,
	output logic [63:0]                cipher_high,
	input  gift128_pkg::gift128_cmd_t  cmd,
	output gift128_pkg::gift128_sts_t  sts
);
	import gift128_pkg::*;

	logic [HALF_W-1:0] key_low_q, key_high_q;
	logic [RND_W-1:0]  round_count_q;
	logic [BLK_W-1:0]  state_q, key_q;
	logic [BLK_W-1:0]  state_nxt, key_nxt;
	logic [HALF_W-1:0] cipher_low_q, cipher_high_q;

	function automatic logic [BLK_W-1:0] round_fn(
		input logic [BLK_W-1:0] s,
		input logic [BLK_W-1:0] k,
		input logic [5:0]       rc
	);
		logic [BLK_W-1:0] sub;
		logic [BLK_W-1:0] perm;
		logic [6:0]       dst;
		for (int n = 0; n < 32; n++) begin
			sub[4*n +: 4] = SBOX[s[4*n +: 4]];
		end
		perm = '0;
		for (int b = 0; b < 128; b++) begin
			dst = 7'((b >> 4) << 2) + PERM_BASE[4'(b)];
			perm[dst] = sub[b];
		end
		for (int i = 0; i < 32; i++) begin
			perm[4*i+1] = perm[4*i+1] ^ k[i];
			perm[4*i+2] = perm[4*i+2] ^ k[64+i];
		end
		for (int i = 0; i < 6; i++) begin
			perm[4*i+3] = perm[4*i+3] ^ rc[i];
		end
		perm[127] = ~perm[127];
		return perm;
	endfunction

	assign state_nxt = round_fn(state_q, key_q, round_const(cmd.round_idx));
	// key schedule: rotate right 32, then rotate the two top words
	assign key_nxt = {key_q[17:16], key_q[31:18], key_q[11:0], key_q[15:12],
		key_q[127:96], key_q[95:64], key_q[63:32]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q     <= '0;
			key_high_q    <= '0;
			round_count_q <= RESET_ROUNDS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LOW:     key_low_q     <= cfg_data;
				REG_KEY_HIGH:    key_high_q    <= cfg_data;
				REG_ROUND_COUNT: round_count_q <= cfg_data[RND_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= {data_high, data_low};
			key_q   <= {key_high_q, key_low_q};
		end else if (cmd.step) begin
			state_q <= state_nxt;
			key_q   <= key_nxt;
		end
		if (cmd.out_load) begin
			cipher_low_q  <= state_q[HALF_W-1:0];
			cipher_high_q <= state_q[BLK_W-1:HALF_W];
		end
	end

	assign sts.rounds  = (round_count_q > MAX_ROUNDS) ? MAX_ROUNDS : round_count_q;
	assign cipher_low  = cipher_low_q;
	assign cipher_high = cipher_high_q;

endmodule

// ===== hw/rtl/gift128_block_encrypt.sv =====
// GIFT-128 block encryption core, one round per clock.
//
// Input channel: data_low/data_high carry the 128-bit plaintext; a request is
// taken when in_valid is high and in_stall is low. in_stall is low only while
// the core is idle, so one block is in flight at a time.
// Output channel: cipher_low/cipher_high, qualified by out_valid; the receiver
// holds it with out_stall. The result sits in its own output register, so a
// new request is taken while an earlier result still waits.
// Sequence: the accept edge loads the state register, then R rounds run
// (R = round_count, saturated at 40; R = 0 passes the plaintext through),
// then the finished state moves to the output register and out_valid
// rises. The core then returns to idle; it works on one request at a time,
// as it has a single shared round unit.
// Key and round count come from the write port (cfg_we/cfg_index/cfg_data,
// index 0 key_low, 1 key_high, 2 round_count); write them only while idle.
// Every block restarts from the master key.
// If the receiver stalls, the finished block waits in the state register and
// the core takes no new request until the output register frees up.
// Reset (arst_n low) clears the key to zero, round_count to 40 and drops
// out_valid; any block in flight is lost.
module gift128_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_low,
	input  logic [63:0] data_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_low,
	output logic [63:0] cipher_high
);
	import gift128_pkg::*;

	gift128_cmd_t cmd;   // controller -> datapath
	gift128_sts_t sts;   // datapath -> controller

	gift128_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gift128_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_low    (data_low),
		.data_high   (data_high),
		.cipher_low  (cipher_low),
		.cipher_high (cipher_high),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ===== hw/rtl/gift128_chk.sv =====
module gift128_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] cipher_low,
	input logic [63:0] cipher_high
);

	// one block in flight: after a request is taken the core is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core took a request back to back");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_low) && $stable(cipher_high))
		else $error("stalled result changed or dropped");

	// a fresh result only appears at the end of a busy period
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while core was idle");

endmodule

bind gift128_block_encrypt gift128_chk u_gift128_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.cipher_low  (cipher_low),
	.cipher_high (cipher_high)
);

// ===== tb/gift128_block_encrypt_tb.sv =====
`timescale 1ns / 1ps

// GIFT-128 encryption core testbench.
// Plaintext requests are queued by the stimulus block and presented by a
// clocked driver; every accepted request is encrypted by a local GIFT-128
// model using the key and round count the testbench last wrote, and the
// result is queued. A clocked monitor takes results off the output channel
// and compares both halves against the oldest queued ciphertext.
module gift128_block_encrypt_tb;
	import gift128_pkg::*;

	// index 3 has no register behind it; writes there must not disturb anything
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam logic [3:0] sbox_lut [16] = '{
		4'h1, 4'hA, 4'h4, 4'hC, 4'h6, 4'hF, 4'h3, 4'h9,
		4'h2, 4'hD, 4'hB, 4'h7, 4'h5, 4'h0, 4'h8, 4'hE
	};

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} blk128_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_KEY_LOW;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] data_low = '0;
	logic [63:0] data_high = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] cipher_low;
	logic [63:0] cipher_high;

	// testbench copy of the configuration registers
	logic [127:0] master_key = '0;
	logic [5:0]   round_cfg = RESET_ROUNDS;

	blk128_t plaintext_q [$];   // requests not yet presented
	blk128_t ciphertext_q [$];  // expected results, oldest first

	int unsigned sender_gap_pct = 0;
	int unsigned receiver_hold_pct = 0;
	int unsigned error_count = 0;

	gift128_block_encrypt dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_low   (data_low),
		.data_high  (data_high),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cipher_low (cipher_low),
		.cipher_high(cipher_high)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// GIFT-128 encryption of one block.
	// Round: S-box on all nibbles, bit permutation, round key into bits
	// 4i+1 / 4i+2, round constant into bits 4i+3 (i < 6), flip bit 127,
	// then the key schedule step. Round constants come from the 6-bit
	// LFSR c <= {c[4:0], c[5]^c[4]^1} starting at zero.
	// A round count above 40 saturates; zero passes the block through.
	// ------------------------------------------------------------------
	function automatic blk128_t gift_encrypt(input blk128_t pt, input logic [127:0] mkey,
			input logic [5:0] rounds_cfg);
		logic [127:0] st;
		logic [127:0] nx;
		logic [127:0] rk;
		logic [5:0]   lfsr;
		int unsigned  nrounds;
		int unsigned  r;
		int unsigned  b;
		int unsigned  dest;
		st = {pt.hi, pt.lo};
		rk = mkey;
		lfsr = 6'd0;
		nrounds = (rounds_cfg > MAX_ROUNDS) ? 40 : rounds_cfg;
		for (r = 0; r < nrounds; r++) begin
			lfsr = {lfsr[4:0], lfsr[5] ^ lfsr[4] ^ 1'b1};
			for (b = 0; b < 32; b++) begin
				st[4*b +: 4] = sbox_lut[st[4*b +: 4]];
			end
			for (b = 0; b < 128; b++) begin
				dest = 4 * (b / 16) + 32 * ((3 * ((b % 16) / 4) + (b % 4)) % 4) + (b % 4);
				nx[dest] = st[b];
			end
			for (b = 0; b < 32; b++) begin
				nx[4*b+1] = nx[4*b+1] ^ rk[b];
				nx[4*b+2] = nx[4*b+2] ^ rk[64+b];
			end
			for (b = 0; b < 6; b++) begin
				nx[4*b+3] = nx[4*b+3] ^ lfsr[b];
			end
			nx[127] = ~nx[127];
			st = nx;
			// key schedule: rotate right 32, then rotate the top two words
			rk = {rk[31:0], rk[127:32]};
			rk[111:96] = {rk[107:96], rk[111:108]};
			rk[127:112] = {rk[113:112], rk[127:114]};
		end
		return blk128_t'(st);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued requests. Valid is decided without looking
	// at stall; a stalled request holds its payload. The request is
	// encrypted locally at the edge where it is taken.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_low <= '0;
			data_high <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				ciphertext_q.push_back(gift_encrypt({data_high, data_low}, master_key,
					round_cfg));
			end
			if (!in_valid || !in_stall) begin
				if (plaintext_q.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
					blk128_t nxt;
					nxt = plaintext_q.pop_front();
					in_valid <= 1'b1;
					data_low <= nxt.lo;
					data_high <= nxt.hi;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random receiver stall, result check against the oldest
	// expected ciphertext.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (ciphertext_q.size() == 0) begin
					error_count++;
					if (error_count <= 10) begin
						$display("%0t: unexpected result %h_%h", $realtime, cipher_high,
							cipher_low);
					end
				end else begin
					blk128_t want;
					want = ciphertext_q.pop_front();
					if (cipher_low !== want.lo || cipher_high !== want.hi) begin
						error_count++;
						if (error_count <= 10) begin
							$display("%0t: cipher_low exp %h got %h, cipher_high exp %h got %h",
								$realtime, want.lo, cipher_low, want.hi, cipher_high);
						end
					end
				end
			end
			out_stall <= ($urandom_range(99) < receiver_hold_pct);
		end
	end

	// register write; the local copy follows, index 3 is dropped
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_KEY_LOW:     master_key[63:0] = val;
			REG_KEY_HIGH:    master_key[127:64] = val;
			REG_ROUND_COUNT: round_cfg = val[5:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_block(input logic [63:0] lo, input logic [63:0] hi);
		plaintext_q.push_back('{hi: hi, lo: lo});
	endtask

	// wait until every request is taken and every result is back; the
	// core is then idle and registers may be written. Sampled on the
	// falling edge so the driver's updates of the rising edge are settled.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (plaintext_q.size() != 0 || in_valid || ciphertext_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned regime;
		int unsigned ph;
		int unsigned n;
		logic [5:0]  rsel;
		logic [63:0] wdata;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		sender_gap_pct = 11;
		receiver_hold_pct = 87;

		// reset values: zero key, 40 rounds
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block({16{4'h5}}, {16{4'h5}});
		queue_block({16{4'hA}}, {16{4'hA}});
		queue_block(64'h1, 64'h0);
		queue_block(64'h0, 64'h8000_0000_0000_0000);
		wait_drained();

		// all-ones key
		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_KEY_HIGH, '1);
		queue_block('0, '0);
		queue_block('1, '1);
		wait_drained();

		// zero rounds: plaintext passes straight through
		write_reg(REG_ROUND_COUNT, 64'd0);
		queue_block(rand64(), rand64());
		queue_block('1, '1);
		wait_drained();

		// single round under a random key
		write_reg(REG_KEY_LOW, rand64());
		write_reg(REG_KEY_HIGH, rand64());
		write_reg(REG_ROUND_COUNT, 64'd1);
		queue_block(rand64(), rand64());
		queue_block('0, '0);
		wait_drained();

		// round count beyond 40 saturates; all-ones data also checks the
		// upper data bits are dropped
		write_reg(REG_ROUND_COUNT, '1);
		queue_block(rand64(), rand64());
		queue_block('1, '0);
		wait_drained();
		write_reg(REG_ROUND_COUNT, 64'd41);
		queue_block(rand64(), rand64());
		wait_drained();

		// write to the unused index must change nothing
		write_reg(REG_UNUSED, rand64());
		queue_block(rand64(), rand64());
		wait_drained();

		write_reg(REG_KEY_LOW, {16{4'hA}});
		write_reg(REG_KEY_HIGH, {16{4'h5}});
		write_reg(REG_ROUND_COUNT, 64'd40);
		queue_block(rand64(), rand64());
		wait_drained();

		// random part: three idling regimes, several settings each
		for (regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					sender_gap_pct = 11;
					receiver_hold_pct = 87;
				end
				1: begin
					sender_gap_pct = 87;
					receiver_hold_pct = 11;
				end
				default: begin
					sender_gap_pct = 0;
					receiver_hold_pct = 0;
				end
			endcase
			for (ph = 0; ph < 6; ph++) begin
				case (ph)
					0: rsel = 6'd40;
					1: rsel = 6'd1;
					2: rsel = 6'd0;
					3: rsel = 6'($urandom_range(63, 41));
					default: rsel = 6'($urandom_range(40, 1));
				endcase
				wdata = rand64();
				wdata[5:0] = rsel;
				write_reg(REG_KEY_LOW, rand64());
				write_reg(REG_KEY_HIGH, rand64());
				write_reg(REG_ROUND_COUNT, wdata);
				for (n = 0; n < 44; n++) begin
					queue_block(rand64(), rand64());
				end
				wait_drained();
			end
		end

		// let any stray result show up before judging
		repeat (50) @(posedge clk);
		if (error_count == 0 && ciphertext_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// hard stop: far above the slowest legal run
	initial begin : watchdog
		#800000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/gift128_pkg.sv
hw/rtl/gift128_ctrl.sv
hw/rtl/gift128_dp.sv
hw/rtl/gift128_block_encrypt.sv
hw/rtl/gift128_chk.sv
tb/gift128_block_encrypt_tb.sv
